FILE: rtl/core/u8vf_pkg.sv
// shared types and constants for the utf-8 validate and fix core
`timescale 1ns / 1ps

package u8vf_pkg;

	// replacement character '?'
	localparam logic [7:0] QMARK = 8'h3F;

	// most result bytes one input byte can cause
	localparam int RUN_MAX = 4;
	localparam int RUN_IW  = $clog2(RUN_MAX);

	// depth of the run queue between front and back
	localparam int RUN_DEPTH = 4;
	localparam int RUN_AW    = $clog2(RUN_DEPTH);
	localparam int RUN_CW    = $clog2(RUN_DEPTH + 1);

	// code point limits
	localparam logic [20:0] CP_MIN2     = 21'h00080;
	localparam logic [20:0] CP_MIN3     = 21'h00800;
	localparam logic [20:0] CP_SURR_LO  = 21'h0D800;
	localparam logic [20:0] CP_SURR_HI  = 21'h0DFFF;
	localparam logic [20:0] CP_NONCHAR  = 21'h0FFFE;
	localparam logic [20:0] CP_MIN4     = 21'h10000;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_last;
	} u8vf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
		logic       string_ok;
	} u8vf_out_t;

	// one run of result bytes caused by a single input byte
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [RUN_IW-1:0]       last_idx;
		logic                    str_end;
		logic                    str_ok;
	} u8vf_run_t;

endpackage

FILE: rtl/core/utf8_validate_and_fix_core.sv
// top level of the utf-8 validate and fix core
//
//   channel  | handshake        | transfer when      | payload
//   ---------+------------------+--------------------+---------------------------------
//   input    | push / full      | push && !full      | item: in_byte, string_last
//   result   | empty / pop      | pop && !empty      | result: out_byte, run_last,
//            |                  |                    |   string_end, string_ok
//
// one input byte per cycle is taken while the run queue has room; results leave
// at one byte per cycle from the output register while pop is held, so the
// sustained rate is one byte per cycle each way when the result side does not
// stall. a result byte passes through the run queue and then the output register
// before it shows up on the result ports. reset is asynchronous and clears the
// queue, the sequence tracker and the output valid flag; the core is ready right
// after. a stalled result side backs up into the run queue and then raises full.
`timescale 1ns / 1ps

module utf8_validate_and_fix_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  u8vf_pkg::u8vf_in_t  item,
	output logic                empty,
	input  logic                pop,
	output u8vf_pkg::u8vf_out_t result
);
	import u8vf_pkg::*;

	logic      accept;
	logic      run_wr;
	u8vf_run_t run_in;
	u8vf_run_t run_head;
	logic      q_empty;
	logic      head_done;

	// input transfer
	assign accept = push && !full;

	// front: classify byte, hold open sequence, build the run it releases
	u8vf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.run_wr (run_wr),
		.run    (run_in)
	);

	// run queue decouples the front from the byte serializer
	u8vf_run_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (run_wr),
		.wr_run (run_in),
		.full   (full),
		.rd     (head_done),
		.rd_run (run_head),
		.empty  (q_empty)
	);

	// back: one result byte per cycle into the output register while it is free or popped
	u8vf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (run_head),
		.head_vld  (!q_empty),
		.head_done (head_done),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

FILE: rtl/core/u8vf_front.sv
// front part: classifies each byte, tracks the open sequence and builds result runs
`timescale 1ns / 1ps

module u8vf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  u8vf_pkg::u8vf_in_t  item,
	output logic                run_wr,
	output u8vf_pkg::u8vf_run_t run
);
	import u8vf_pkg::*;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_BAD
	} cls_t;

	logic [7:0]  held_q [3];
	logic [1:0]  hc_q;
	logic [1:0]  left_q;
	logic [1:0]  len_q;
	logic        repl_q;

	logic [7:0]  b;
	logic        last;
	logic        is_cont;
	cls_t        cls;
	logic [1:0]  lead_len;
	logic [20:0] cp;
	logic        seq_ok;
	logic        emit;
	logic        bad;
	logic        hold_lead;
	logic        hold_cont;
	logic [RUN_MAX-1:0][7:0] d;

	assign b       = item.in_byte;
	assign last    = item.string_last;
	assign is_cont = (b[7:6] == 2'b10);

	always_comb begin
		priority if (b[7] == 1'b0) begin
			cls = CLS_ASCII;
		end else if (b[7:5] == 3'b110) begin
			cls = CLS_LEAD2;
		end else if (b[7:4] == 4'b1110) begin
			cls = CLS_LEAD3;
		end else if (b[7:3] == 5'b11110) begin
			cls = CLS_LEAD4;
		end else begin
			cls = CLS_BAD;
		end
	end

	always_comb begin
		unique case (cls)
			CLS_LEAD2: lead_len = 2'd1;
			CLS_LEAD3: lead_len = 2'd2;
			CLS_LEAD4: lead_len = 2'd3;
			default:   lead_len = 2'd0;
		endcase
	end

	// code point of the sequence completed by this byte
	always_comb begin
		unique case (len_q)
			2'd1: begin
				cp     = {10'd0, held_q[0][4:0], b[5:0]};
				seq_ok = (cp >= CP_MIN2);
			end
			2'd2: begin
				cp     = {5'd0, held_q[0][3:0], held_q[1][5:0], b[5:0]};
				seq_ok = (cp >= CP_MIN3) && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI))
					&& (cp < CP_NONCHAR);
			end
			2'd3: begin
				cp     = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]};
				seq_ok = (cp >= CP_MIN4) && (cp <= CP_MAX);
			end
			default: begin
				cp     = '0;
				seq_ok = 1'b0;
			end
		endcase
	end

	// decide whether this byte releases a run, and whether it is all replaced
	always_comb begin
		emit      = 1'b0;
		bad       = 1'b0;
		hold_lead = 1'b0;
		hold_cont = 1'b0;
		if (left_q == 2'd0) begin
			unique case (cls)
				CLS_ASCII: emit = 1'b1;
				CLS_BAD: begin
					emit = 1'b1;
					bad  = 1'b1;
				end
				default: begin
					// lead byte cut off by string end
					emit      = last;
					bad       = last;
					hold_lead = !last;
				end
			endcase
		end else if (!is_cont) begin
			emit = 1'b1;
			bad  = 1'b1;
		end else if (left_q > 2'd1) begin
			emit      = last;
			bad       = last;
			hold_cont = !last;
		end else begin
			emit = 1'b1;
			bad  = !seq_ok;
		end
	end

	assign d[0] = (hc_q != 2'd0) ? held_q[0] : b;
	assign d[1] = (hc_q > 2'd1)  ? held_q[1] : b;
	assign d[2] = (hc_q > 2'd2)  ? held_q[2] : b;
	assign d[3] = b;

	always_comb begin
		for (int k = 0; k < RUN_MAX; k++) begin
			run.bytes[k] = bad ? QMARK : d[k];
		end
		run.last_idx = hc_q;
		run.str_end  = last;
		run.str_ok   = !(repl_q || bad);
	end

	assign run_wr = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q   <= '0;
			left_q <= '0;
			len_q  <= '0;
			repl_q <= 1'b0;
		end else if (accept) begin
			repl_q <= last ? 1'b0 : (repl_q || bad);
			if (hold_lead) begin
				hc_q   <= 2'd1;
				left_q <= lead_len;
				len_q  <= lead_len;
			end else if (hold_cont) begin
				hc_q   <= hc_q + 2'd1;
				left_q <= left_q - 2'd1;
			end else begin
				hc_q   <= '0;
				left_q <= '0;
				len_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_lead) begin
			held_q[0] <= b;
		end
		if (accept && hold_cont) begin
			held_q[hc_q] <= b;
		end
	end

endmodule

FILE: rtl/core/u8vf_run_fifo.sv
// short queue of result runs between front and back
`timescale 1ns / 1ps

module u8vf_run_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  u8vf_pkg::u8vf_run_t wr_run,
	output logic                full,
	input  logic                rd,
	output u8vf_pkg::u8vf_run_t rd_run,
	output logic                empty
);
	import u8vf_pkg::*;

	u8vf_run_t         mem_q [RUN_DEPTH];
	logic [RUN_AW-1:0] wp_q;
	logic [RUN_AW-1:0] rp_q;
	logic [RUN_CW-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full   = (cnt_q == RUN_CW'(RUN_DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_run = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == RUN_AW'(RUN_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == RUN_AW'(RUN_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/u8vf_back.sv
// back part: walks the head run one byte a cycle, unless pop stalls, into the output register
`timescale 1ns / 1ps

module u8vf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  u8vf_pkg::u8vf_run_t    head,
	input  logic                   head_vld,
	output logic                   head_done,
	output u8vf_pkg::u8vf_out_t    result,
	output logic                   empty,
	input  logic                   pop
);
	import u8vf_pkg::*;

	u8vf_out_t         out_q;
	logic              vld_q;
	logic [RUN_IW-1:0] idx_q;
	logic              load;
	logic              at_end;

	assign load      = head_vld && (!vld_q || pop);
	assign at_end    = (idx_q == head.last_idx);
	assign head_done = load && at_end;
	assign result    = out_q;
	assign empty     = !vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= at_end ? '0 : idx_q + 1'b1;
		end else if (pop) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte   <= head.bytes[idx_q];
			out_q.run_last   <= at_end;
			out_q.string_end <= at_end && head.str_end;
			out_q.string_ok  <= at_end && head.str_end && head.str_ok;
		end
	end

endmodule

FILE: rtl/core/u8vf_checker.sv
// port checker for the utf-8 validate and fix core, with its bind
`timescale 1ns / 1ps

module u8vf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input u8vf_pkg::u8vf_out_t result
);

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	// string end closes a run
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.string_end) |-> result.run_last)
		else $error("string_end without run_last");

	// ok flag only with string end
	a_ok_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.string_ok) |-> result.string_end)
		else $error("string_ok without string_end");

	// a waiting result carries no unknown bits
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown(result))
		else $error("unknown bits on a waiting result");

endmodule

bind utf8_validate_and_fix_core u8vf_checker u_chk (.*);
